### sv/mhtq_pkg.sv
// Package for the min-heap timer queue: sizes, codes and command/status types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mhtq_pkg;
  localparam int CAPACITY = 32;
  localparam int ID_COUNT = 1024;
  localparam int TIME_BITS = 32;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ID_W = 10;

  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_ADJUST = 3'd1;
  localparam logic [2:0] REQ_TICK = 3'd2;
  localparam logic [2:0] REQ_POP = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [2:0] KIND_DONE = 3'd0;
  localparam logic [2:0] KIND_EXPIRED = 3'd1;
  localparam logic [2:0] KIND_FULL = 3'd2;
  localparam logic [2:0] KIND_UNKNOWN = 3'd3;
  localparam logic [2:0] KIND_EMPTY = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,
    OP_LOOKUP = 4'd2,
    OP_WRITE_NEW = 4'd3,
    OP_REARM = 4'd4,
    OP_READ_I = 4'd5,
    OP_READ_KIDS = 4'd6,
    OP_SWAP_DOWN = 4'd7,
    OP_READ_PARENT = 4'd8,
    OP_SWAP_UP = 4'd9,
    OP_MOVE_LAST = 4'd10,
    OP_FINISH_POP = 4'd11,
    OP_ADVANCE = 4'd12,
    OP_CLEAR = 4'd13,
    OP_CLEAR_STEP = 4'd14,
    OP_READ_ROOT = 4'd15
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic emit;
    logic [2:0] kind;
    logic use_ev;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic present;
    logic full;
    logic empty;
    logic single;
    logic has_kid;
    logic down_go;
    logic moved_down;
    logic up_go;
    logic at_root;
    logic root_due;
    logic clear_done;
    logic out_busy;
    logic [2:0] req;
    logic [5:0] emitted;
  } dp_status_t;
endpackage
`default_nettype wire

### sv/mhtq_datapath.sv
// Datapath of the timer queue: heap memories, id maps, clock and result register.
// Depends on mhtq_pkg; driven by mhtq_ctrl.
`default_nettype none
module mhtq_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_take,
  input  wire logic [2:0] req_type,
  input  wire logic [9:0] timer_id,
  input  wire logic [23:0] timeout_ms,
  input  wire logic [15:0] elapsed_ms,
  input  wire mhtq_pkg::dp_cmd_t cmd,
  output mhtq_pkg::dp_status_t status,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [2:0] result_kind,
  output logic [9:0] event_id,
  output logic [31:0] next_wait_ms,
  output logic has_next,
  output logic last
);
  localparam int SW = mhtq_pkg::SLOT_W;
  localparam int TW = mhtq_pkg::TIME_BITS;

  logic [9:0] heap_ids [mhtq_pkg::CAPACITY];
  logic [TW-1:0] heap_expiry [mhtq_pkg::CAPACITY];
  logic [SW-1:0] slot_of_id [mhtq_pkg::ID_COUNT];
  logic id_present [mhtq_pkg::ID_COUNT];
  logic [mhtq_pkg::CNT_W-1:0] timer_count;
  logic [TW-1:0] current_time;

  logic [2:0] req;
  logic [9:0] rid;
  logic [23:0] rto;
  logic [15:0] rel;
  logic [SW-1:0] pos;
  logic [9:0] cur_id, a_id, b_id;
  logic [TW-1:0] cur_ex, a_ex, b_ex;
  logic [SW:0] kid_l;
  logic b_ok, moved;
  logic [5:0] emitted;
  logic [9:0] clr_idx;
  logic [SW-1:0] slot_rd;
  logic pres_rd;
  logic [9:0] last_ev;

  function automatic logic earlier(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW-1:0] d;
    d = a - b;
    return d[TW-1];
  endfunction

  logic pick_b;
  logic [9:0] kid_id;
  logic [TW-1:0] kid_ex;
  logic [SW:0] kid_pos;
  logic [SW-1:0] parent;
  logic [mhtq_pkg::CNT_W-1:0] cnt_m1;
  logic [TW-1:0] root_d;

  assign b_ok = (mhtq_pkg::CNT_W+1)'(kid_l) + (mhtq_pkg::CNT_W+1)'(1)
      < (mhtq_pkg::CNT_W+1)'(timer_count);
  assign pick_b = b_ok && earlier(b_ex, a_ex);
  assign kid_id = pick_b ? b_id : a_id;
  assign kid_ex = pick_b ? b_ex : a_ex;
  assign kid_pos = pick_b ? kid_l + 1'b1 : kid_l;
  assign parent = SW'((pos - 1'b1) >> 1);
  assign cnt_m1 = timer_count - 1'b1;
  assign root_d = heap_expiry[0] - current_time;

  always_comb begin
    status.present = pres_rd;
    status.full = timer_count >= mhtq_pkg::CNT_W'(mhtq_pkg::CAPACITY);
    status.empty = timer_count == '0;
    status.single = timer_count == mhtq_pkg::CNT_W'(1);
    status.has_kid = (mhtq_pkg::CNT_W+1)'(kid_l) < (mhtq_pkg::CNT_W+1)'(timer_count);
    status.down_go = !earlier(cur_ex, kid_ex);
    status.moved_down = moved;
    status.up_go = earlier(cur_ex, a_ex);
    status.at_root = pos == '0;
    status.root_due = (root_d == '0) || root_d[TW-1];
    status.clear_done = clr_idx == 10'(mhtq_pkg::ID_COUNT - 1);
    status.out_busy = out_valid;
    status.req = req;
    status.emitted = emitted;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req <= req_type;
      rid <= timer_id;
      rto <= timeout_ms;
      rel <= elapsed_ms;
    end
    slot_rd <= slot_of_id[rid];
    pres_rd <= id_present[rid];
    a_id <= heap_ids[SW'(kid_l)];
    a_ex <= heap_expiry[SW'(kid_l)];
    b_id <= heap_ids[SW'(kid_l + 1'b1)];
    b_ex <= heap_expiry[SW'(kid_l + 1'b1)];
    unique case (cmd.op)
      mhtq_pkg::OP_NONE: ;
      mhtq_pkg::OP_LOAD: begin
        emitted <= '0;
        moved <= 1'b0;
      end
      mhtq_pkg::OP_LOOKUP: ;
      mhtq_pkg::OP_WRITE_NEW: begin
        pos <= SW'(timer_count);
        heap_ids[SW'(timer_count)] <= rid;
        heap_expiry[SW'(timer_count)] <= current_time + TW'(rto);
        slot_of_id[rid] <= SW'(timer_count);
        cur_id <= rid;
        cur_ex <= current_time + TW'(rto);
        kid_l <= (SW+1)'(timer_count);
      end
      mhtq_pkg::OP_REARM: begin
        pos <= slot_rd;
        heap_expiry[slot_rd] <= current_time + TW'(rto);
        cur_id <= rid;
        cur_ex <= current_time + TW'(rto);
        kid_l <= {slot_rd, 1'b1};
      end
      mhtq_pkg::OP_READ_I: kid_l <= {pos, 1'b1};
      mhtq_pkg::OP_READ_KIDS: ;
      mhtq_pkg::OP_SWAP_DOWN: begin
        heap_ids[pos] <= kid_id;
        heap_expiry[pos] <= kid_ex;
        slot_of_id[kid_id] <= pos;
        heap_ids[SW'(kid_pos)] <= cur_id;
        heap_expiry[SW'(kid_pos)] <= cur_ex;
        slot_of_id[cur_id] <= SW'(kid_pos);
        pos <= SW'(kid_pos);
        kid_l <= {SW'(kid_pos), 1'b1};
        moved <= 1'b1;
      end
      mhtq_pkg::OP_READ_PARENT: kid_l <= {1'b0, parent};
      mhtq_pkg::OP_SWAP_UP: begin
        heap_ids[pos] <= a_id;
        heap_expiry[pos] <= a_ex;
        slot_of_id[a_id] <= pos;
        heap_ids[SW'(kid_l)] <= cur_id;
        heap_expiry[SW'(kid_l)] <= cur_ex;
        slot_of_id[cur_id] <= SW'(kid_l);
        pos <= SW'(kid_l);
      end
      mhtq_pkg::OP_READ_ROOT: kid_l <= {SW'(cnt_m1), 1'b0} >> 1;
      mhtq_pkg::OP_MOVE_LAST: begin
        last_ev <= heap_ids[0];
        id_present[heap_ids[0]] <= 1'b0;
        heap_ids[0] <= heap_ids[SW'(cnt_m1)];
        heap_expiry[0] <= heap_expiry[SW'(cnt_m1)];
        slot_of_id[heap_ids[SW'(cnt_m1)]] <= '0;
        cur_id <= heap_ids[SW'(cnt_m1)];
        cur_ex <= heap_expiry[SW'(cnt_m1)];
        pos <= '0;
        kid_l <= (SW+1)'(1);
        timer_count <= cnt_m1;
      end
      mhtq_pkg::OP_FINISH_POP: begin
        last_ev <= heap_ids[0];
        id_present[heap_ids[0]] <= 1'b0;
        timer_count <= cnt_m1;
      end
      mhtq_pkg::OP_ADVANCE: current_time <= current_time + TW'(rel);
      mhtq_pkg::OP_CLEAR: begin
        timer_count <= '0;
        clr_idx <= '0;
      end
      mhtq_pkg::OP_CLEAR_STEP: begin
        id_present[clr_idx] <= 1'b0;
        clr_idx <= clr_idx + 1'b1;
      end
      default: ;
    endcase
    if (cmd.op == mhtq_pkg::OP_WRITE_NEW) begin
      id_present[rid] <= 1'b1;
      timer_count <= timer_count + 1'b1;
    end
    if (cmd.emit) begin
      result_kind <= cmd.kind;
      event_id <= cmd.use_ev ? last_ev : '0;
      has_next <= timer_count != '0;
      last <= cmd.last;
      next_wait_ms <= (timer_count == '0 || status.root_due || !cmd.last) ? '0 : root_d;
      emitted <= emitted + 1'b1;
    end
    if (rst) begin
      timer_count <= '0;
      current_time <= '0;
      clr_idx <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
endmodule
`default_nettype wire

### sv/mhtq_ctrl.sv
// Sequencer of the timer queue: walks each request through heap steps.
// Depends on mhtq_pkg; drives mhtq_datapath.
`default_nettype none
module mhtq_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire mhtq_pkg::dp_status_t status,
  output mhtq_pkg::dp_cmd_t cmd
);
  typedef enum logic [16:0] {
    S_IDLE = 17'h00001, S_DISPATCH = 17'h00002, S_LOOK = 17'h00004,
    S_LOOK2 = 17'h00008, S_KIDS = 17'h00010, S_DOWN = 17'h00020,
    S_PARENT = 17'h00040, S_UP = 17'h00080, S_ROOT = 17'h00100,
    S_MOVE = 17'h00200, S_CHECK = 17'h00400, S_CLEAR = 17'h00800,
    S_FINAL = 17'h01000, S_POPEMIT = 17'h02000, S_KIDS2 = 17'h04000,
    S_PARENT2 = 17'h08000, S_INIT = 17'h10000
  } state_t;

  state_t state, state_next;
  logic pop_mode, pop_mode_next, tick_mode, tick_mode_next;
  logic [2:0] fin_kind, fin_kind_next;
  logic fin_ev, fin_ev_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    pop_mode_next = pop_mode;
    tick_mode_next = tick_mode;
    fin_kind_next = fin_kind;
    fin_ev_next = fin_ev;
    cmd = '{op: mhtq_pkg::OP_NONE, emit: 1'b0, kind: mhtq_pkg::KIND_DONE,
            use_ev: 1'b0, last: 1'b0};
    unique case (state)
      S_INIT: begin
        cmd.op = mhtq_pkg::OP_CLEAR_STEP;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.op = mhtq_pkg::OP_LOAD;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        fin_kind_next = mhtq_pkg::KIND_DONE;
        fin_ev_next = 1'b0;
        pop_mode_next = 1'b0;
        tick_mode_next = 1'b0;
        case (status.req)
          mhtq_pkg::REQ_ADD, mhtq_pkg::REQ_ADJUST: begin
            cmd.op = mhtq_pkg::OP_LOOKUP;
            state_next = S_LOOK;
          end
          mhtq_pkg::REQ_TICK: begin
            cmd.op = mhtq_pkg::OP_ADVANCE;
            tick_mode_next = 1'b1;
            state_next = S_CHECK;
          end
          mhtq_pkg::REQ_POP: begin
            if (status.empty) begin
              fin_kind_next = mhtq_pkg::KIND_EMPTY;
              state_next = S_FINAL;
            end else begin
              fin_ev_next = 1'b1;
              pop_mode_next = 1'b1;
              state_next = S_ROOT;
            end
          end
          mhtq_pkg::REQ_CLEAR: begin
            cmd.op = mhtq_pkg::OP_CLEAR;
            state_next = S_CLEAR;
          end
          default: state_next = S_FINAL;
        endcase
      end
      S_LOOK: begin
        if (status.present) state_next = S_LOOK2;
        else if (status.req == mhtq_pkg::REQ_ADJUST) begin
          fin_kind_next = mhtq_pkg::KIND_UNKNOWN;
          state_next = S_FINAL;
        end else if (status.full) begin
          fin_kind_next = mhtq_pkg::KIND_FULL;
          state_next = S_FINAL;
        end else begin
          cmd.op = mhtq_pkg::OP_WRITE_NEW;
          state_next = S_PARENT;
        end
      end
      S_LOOK2: begin
        cmd.op = mhtq_pkg::OP_REARM;
        state_next = S_KIDS;
      end
      S_KIDS: state_next = S_KIDS2;
      S_KIDS2: begin
        if (!status.has_kid) state_next = pop_mode ? S_POPEMIT :
            (status.moved_down ? S_FINAL : S_PARENT);
        else state_next = S_DOWN;
      end
      S_DOWN: begin
        if (status.down_go) begin
          cmd.op = mhtq_pkg::OP_SWAP_DOWN;
          state_next = S_KIDS;
        end else state_next = pop_mode ? S_POPEMIT :
            (status.moved_down ? S_FINAL : S_PARENT);
      end
      S_PARENT: begin
        if (status.at_root) state_next = S_FINAL;
        else begin
          cmd.op = mhtq_pkg::OP_READ_PARENT;
          state_next = S_PARENT2;
        end
      end
      S_PARENT2: state_next = S_UP;
      S_UP: begin
        if (status.up_go) begin
          cmd.op = mhtq_pkg::OP_SWAP_UP;
          state_next = S_PARENT;
        end else state_next = S_FINAL;
      end
      S_ROOT: begin
        if (status.single) begin
          cmd.op = mhtq_pkg::OP_FINISH_POP;
          state_next = S_POPEMIT;
        end else begin
          cmd.op = mhtq_pkg::OP_READ_ROOT;
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.op = mhtq_pkg::OP_MOVE_LAST;
        state_next = S_KIDS;
      end
      S_POPEMIT: begin
        pop_mode_next = 1'b0;
        if (tick_mode) begin
          if (!status.out_busy) begin
            cmd.emit = 1'b1;
            cmd.kind = mhtq_pkg::KIND_EXPIRED;
            cmd.use_ev = 1'b1;
            state_next = S_CHECK;
          end
        end else state_next = S_FINAL;
      end
      S_CHECK: begin
        if (!status.empty && status.root_due && status.emitted < 6'd63) begin
          pop_mode_next = 1'b1;
          state_next = S_ROOT;
        end else state_next = S_FINAL;
      end
      S_CLEAR: begin
        cmd.op = mhtq_pkg::OP_CLEAR_STEP;
        if (status.clear_done) state_next = S_FINAL;
      end
      S_FINAL: if (!status.out_busy) begin
        cmd.emit = 1'b1;
        cmd.kind = fin_kind;
        cmd.use_ev = fin_ev;
        cmd.last = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      pop_mode <= 1'b0;
      tick_mode <= 1'b0;
      fin_kind <= mhtq_pkg::KIND_DONE;
      fin_ev <= 1'b0;
    end else begin
      state <= state_next;
      pop_mode <= pop_mode_next;
      tick_mode <= tick_mode_next;
      fin_kind <= fin_kind_next;
      fin_ev <= fin_ev_next;
    end
  end
endmodule
`default_nettype wire

### sv/min_heap_timer_queue.sv
// Add, adjust and pop sift an entry up or down one level at a time through the 32-entry
// heap; each tick expiry adds a root removal and its sift-down.
// Clear walks the 1024-entry presence map, one id per cycle.
// One request is handled at a time; results leave through a registered output beat.
// Synchronous active-high reset empties the heap and zeroes the clock, then a pass over all
// 1024 ids clears the presence map before the first request is taken.
`default_nettype none
module min_heap_timer_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [2:0] req_type,
  input  wire logic [9:0] timer_id,
  input  wire logic [23:0] timeout_ms,
  input  wire logic [15:0] elapsed_ms,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [2:0] result_kind,
  output logic [9:0] event_id,
  output logic [31:0] next_wait_ms,
  output logic has_next,
  output logic last
);
  mhtq_pkg::dp_cmd_t cmd;
  mhtq_pkg::dp_status_t status;

  mhtq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .status(status), .cmd(cmd)
  );

  mhtq_datapath u_dp (
    .clk(clk), .rst(rst), .in_take(in_valid && in_ready),
    .req_type(req_type), .timer_id(timer_id), .timeout_ms(timeout_ms),
    .elapsed_ms(elapsed_ms), .cmd(cmd), .status(status),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .event_id(event_id), .next_wait_ms(next_wait_ms), .has_next(has_next),
    .last(last)
  );
endmodule
`default_nettype wire

### sv/mhtq_checker.sv
// Port checker for the timer queue, bound to the top level.
// Depends on the top level's ports and on mhtq_pkg for result codes.
`default_nettype none
module mhtq_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] result_kind,
  input wire logic [9:0] next_wait_ms_lo,
  input wire logic has_next,
  input wire logic last
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_expired_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == mhtq_pkg::KIND_EXPIRED |-> !last)
    else $error("expired beat marked last");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("request taken while busy");
  a_empty_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_next |-> next_wait_ms_lo == '0) else $error("wait on empty heap");
endmodule

bind min_heap_timer_queue mhtq_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
  .next_wait_ms_lo(next_wait_ms[9:0]), .has_next(has_next), .last(last)
);
`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for the min-heap timer queue: drives add, adjust, tick, pop, clear and
// undefined requests and checks every result beat against a scoreboard predictor.
// Depends on mhtq_pkg and min_heap_timer_queue.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  class timer_scoreboard;
    logic [9:0]  ids [mhtq_pkg::CAPACITY];
    logic [31:0] expiry [mhtq_pkg::CAPACITY];
    logic [4:0]  slot [mhtq_pkg::ID_COUNT];
    bit          present [mhtq_pkg::ID_COUNT];
    int          count;
    logic [31:0] now;
    logic [46:0] pending [$];
    int          errors;
    int          checked;

    function void clear_state();
      foreach (present[k]) present[k] = 0;
      count = 0;
    endfunction

    function bit is_earlier(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function void swap_entries(int a, int b);
      logic [9:0]  ti;
      logic [31:0] te;
      ti = ids[a]; te = expiry[a];
      ids[a] = ids[b]; expiry[a] = expiry[b];
      ids[b] = ti; expiry[b] = te;
      slot[ids[a]] = 5'(a);
      slot[ids[b]] = 5'(b);
    endfunction

    function void sift_up(int i);
      int p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!is_earlier(expiry[i], expiry[p])) break;
        swap_entries(i, p);
        i = p;
      end
    endfunction

    function bit sift_down(int start, int n);
      int i;
      int c;
      i = start;
      c = 2 * i + 1;
      while (c < n) begin
        if (c + 1 < n && is_earlier(expiry[c + 1], expiry[c])) c++;
        if (is_earlier(expiry[i], expiry[c])) break;
        swap_entries(i, c);
        i = c;
        c = 2 * i + 1;
      end
      return i > start;
    endfunction

    function logic [9:0] take_root();
      logic [9:0] id;
      id = ids[0];
      if (count > 1) begin
        swap_entries(0, count - 1);
        void'(sift_down(0, count - 1));
      end
      present[id] = 0;
      count--;
      return id;
    endfunction

    function logic [31:0] root_wait();
      logic [31:0] d;
      if (count == 0) return 0;
      d = expiry[0] - now;
      if (d[31]) return 0;
      return d;
    endfunction

    function void push_result(logic [2:0] kind, logic [9:0] id, logic [31:0] w, bit lst);
      logic [46:0] entry;
      entry = {kind, id, w, count != 0, lst};
      pending = {pending, entry};
    endfunction

    function void note_request(logic [2:0] req, logic [9:0] id, logic [23:0] tmo,
                               logic [15:0] el);
      logic [2:0] kind;
      logic [9:0] ev;
      int n;
      int i;
      kind = mhtq_pkg::KIND_DONE;
      ev = 0;
      n = 0;
      if (req == mhtq_pkg::REQ_ADD || req == mhtq_pkg::REQ_ADJUST) begin
        if (present[id]) begin
          i = slot[id];
          expiry[i] = now + tmo;
          if (!sift_down(i, count)) sift_up(i);
        end else if (req == mhtq_pkg::REQ_ADJUST) begin
          kind = mhtq_pkg::KIND_UNKNOWN;
        end else if (count >= mhtq_pkg::CAPACITY) begin
          kind = mhtq_pkg::KIND_FULL;
        end else begin
          i = count;
          ids[i] = id;
          expiry[i] = now + tmo;
          slot[id] = 5'(i);
          present[id] = 1;
          count++;
          sift_up(i);
        end
      end else if (req == mhtq_pkg::REQ_TICK) begin
        now = now + el;
        while (count > 0 && n < 63) begin
          if (root_wait() != 0) break;
          ev = take_root();
          push_result(mhtq_pkg::KIND_EXPIRED, ev, 0, 0);
          n++;
        end
        ev = 0;
      end else if (req == mhtq_pkg::REQ_POP) begin
        if (count == 0) kind = mhtq_pkg::KIND_EMPTY;
        else ev = take_root();
      end else if (req == mhtq_pkg::REQ_CLEAR) begin
        clear_state();
      end
      push_result(kind, ev, root_wait(), 1);
    endfunction

    function void check_result(logic [2:0] kind, logic [9:0] id, logic [31:0] w,
                               logic hn, logic lst);
      logic [46:0] e;
      checked++;
      if (pending.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e[46:44] !== kind) begin
        $error("result_kind expected %0d actual %0d", e[46:44], kind); errors++;
      end
      if (e[43:34] !== id) begin
        $error("event_id expected %0d actual %0d", e[43:34], id); errors++;
      end
      if (e[33:2] !== w) begin
        $error("next_wait_ms expected %0d actual %0d", e[33:2], w); errors++;
      end
      if (e[1] !== hn) begin
        $error("has_next expected %0d actual %0d", e[1], hn); errors++;
      end
      if (e[0] !== lst) begin
        $error("last expected %0d actual %0d", e[0], lst); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] req_type;
  logic [9:0] timer_id;
  logic [23:0] timeout_ms;
  logic [15:0] elapsed_ms;
  logic [2:0] result_kind;
  logic [9:0] event_id;
  logic [31:0] next_wait_ms;
  logic has_next, last;

  timer_scoreboard sb;
  int sent;
  int burst_left;
  logic [9:0] pool [8];

  min_heap_timer_queue uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .timer_id(timer_id), .timeout_ms(timeout_ms),
    .elapsed_ms(elapsed_ms), .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .event_id(event_id), .next_wait_ms(next_wait_ms),
    .has_next(has_next), .last(last)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    int ph;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result(result_kind, event_id, next_wait_ms, has_next, last);
      ph = int'(($time / 20) % 600);
      if (ph < 150) out_ready <= 1;
      else if (ph < 400) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 2) == 0);
    end
  end

  task automatic send_request(logic [2:0] r, logic [9:0] id, logic [23:0] t, logic [15:0] e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    req_type <= r;
    timer_id <= id;
    timeout_ms <= t;
    elapsed_ms <= e;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r, id, t, e);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_request();
    int sel;
    logic [9:0] id;
    logic [23:0] t;
    sel = $urandom_range(0, 99);
    id = ($urandom_range(0, 4) == 0) ? 10'($urandom) : pool[$urandom_range(0, 7)];
    t = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
    if (sel < 35) send_request(mhtq_pkg::REQ_ADD, id, t, 16'($urandom));
    else if (sel < 50) send_request(mhtq_pkg::REQ_ADJUST, id, t, 16'($urandom));
    else if (sel < 78) send_request(mhtq_pkg::REQ_TICK, 10'($urandom), 24'($urandom),
                                    ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 900)));
    else if (sel < 93)
      send_request(mhtq_pkg::REQ_POP, 10'($urandom), 24'($urandom), 16'($urandom));
    else if (sel < 96)
      send_request(mhtq_pkg::REQ_CLEAR, 10'($urandom), 24'($urandom), 16'($urandom));
    else send_request(3'($urandom_range(5, 7)), 10'($urandom), 24'($urandom), 16'($urandom));
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    sb.now = 0;
    sb.errors = 0;
    sb.checked = 0;
    sent = 0;
    burst_left = 0;
    rst = 1;
    in_valid = 0;
    req_type = 0;
    timer_id = 0;
    timeout_ms = 0;
    elapsed_ms = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_request(mhtq_pkg::REQ_POP, 0, 0, 0);
    send_request(mhtq_pkg::REQ_TICK, 0, 0, 16'hFFFF);
    send_request(mhtq_pkg::REQ_ADJUST, 10'd5, 24'd10, 0);
    send_request(mhtq_pkg::REQ_ADD, 10'd0, 24'd0, 0);
    send_request(mhtq_pkg::REQ_ADD, 10'd1023, 24'hFFFFFF, 0);
    send_request(mhtq_pkg::REQ_ADD, 10'd7, 24'd100, 0);
    send_request(mhtq_pkg::REQ_ADD, 10'd8, 24'd100, 0);
    send_request(mhtq_pkg::REQ_ADD, 10'd7, 24'd50, 0);
    send_request(mhtq_pkg::REQ_ADJUST, 10'd1023, 24'd20, 0);
    send_request(mhtq_pkg::REQ_TICK, 0, 0, 16'd60);
    send_request(mhtq_pkg::REQ_POP, 0, 0, 0);
    send_request(3'd5, 10'h3FF, 24'hFFFFFF, 16'hFFFF);
    send_request(3'd7, 0, 0, 0);
    for (int k = 0; k < 33; k++) send_request(mhtq_pkg::REQ_ADD, 10'(k * 31), 24'(k * 7), 0);
    send_request(mhtq_pkg::REQ_ADD, 10'd1, 24'd5, 0);
    send_request(mhtq_pkg::REQ_TICK, 0, 0, 16'hFFFF);
    send_request(mhtq_pkg::REQ_CLEAR, 0, 0, 0);
    drain();

    for (int round = 0; round < 280; round++) begin
      if (round % 60 == 0)
        for (int k = 0; k < 8; k++) pool[k] = 10'($urandom);
      if (round % 60 == 0 && round != 0) begin
        for (int k = 0; k < 20; k++)
          send_request(mhtq_pkg::REQ_ADD, 10'($urandom), 24'($urandom_range(0, 500)), 0);
      end
      random_request();
    end
    drain();

    $display("Sent %0d requests and checked %0d result beats, covering full heap,", sent, sb.checked);
    $display("unknown ids, empty pops, tick expiry bursts, clears and wrap of large timeouts.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

### min_heap_timer_queue.f
sv/mhtq_pkg.sv
sv/mhtq_datapath.sv
sv/mhtq_ctrl.sv
sv/min_heap_timer_queue.sv
sv/mhtq_checker.sv
tb/sv/tb_top.sv
